// ----- rtl/sidc_pkg.sv -----
// shared types, constants and the binary to bcd step function
package sidc_pkg;

  localparam int unsigned VALUE_W         = 32;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned NUM_DIGITS      = 10;
  localparam int unsigned DIGIT_IDX_W     = 4;
  localparam int unsigned DABBLE_STAGES   = 4;
  localparam int unsigned STEPS_PER_STAGE = VALUE_W / DABBLE_STAGES;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

  typedef logic [NUM_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic                 neg;
    bcd_t                 bcd;
    logic [VALUE_W-1:0]   bin;
  } work_t;

  // a group of shift-and-add-three steps on the combined bcd and binary word
  function automatic work_t dabble_steps(work_t w);
    logic [NUM_DIGITS*4+VALUE_W-1:0] s;
    work_t                           r;
    s = {w.bcd, w.bin};
    for (int i = 0; i < int'(STEPS_PER_STAGE); i++) begin
      for (int d = 0; d < int'(NUM_DIGITS); d++) begin
        if (s[VALUE_W+4*d +: 4] >= 4'd5) begin
          s[VALUE_W+4*d +: 4] = s[VALUE_W+4*d +: 4] + 4'd3;
        end
      end
      s = {s[NUM_DIGITS*4+VALUE_W-2:0], 1'b0};
    end
    r.neg = w.neg;
    r.bcd = s[NUM_DIGITS*4+VALUE_W-1:VALUE_W];
    r.bin = s[VALUE_W-1:0];
    return r;
  endfunction

endpackage

// ----- rtl/sidc_dabble_stage.sv -----
// one registered pipeline stage of the binary to bcd conversion
module sidc_dabble_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sidc_pkg::work_t in_work,
  output logic           out_valid,
  input  logic           out_ready,
  output sidc_pkg::work_t out_work
);
  import sidc_pkg::*;

  logic  valid;
  work_t work;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_work  = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      work <= dabble_steps(in_work);
    end
  end

endmodule

// ----- rtl/signed_int_to_decimal_ascii_top.sv -----
// signed integer to decimal ascii converter, pipelined conversion with byte serializer
// an item passes the magnitude, dabble and leading digit registers, then loads the serializer
// the serializer sets item rate: 1 to 11 characters, one per cycle while out_ready is high
// the pipeline takes a new item every cycle and stalls when full behind a busy serializer
// reset: synchronous, clears all stage valid bits and the serializer busy flag, no other state
module signed_int_to_decimal_ascii_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [sidc_pkg::VALUE_W-1:0] value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sidc_pkg::CHAR_W-1:0]    character,
  output logic                           last
);
  import sidc_pkg::*;

  // magnitude stage
  logic  mag_valid;
  work_t mag_work;
  logic  mag_ready;

  logic  [DABBLE_STAGES:0] dv;
  logic  [DABBLE_STAGES:0] dr;
  work_t                   dw [DABBLE_STAGES+1];

  // leading digit stage
  logic                   lz_valid;
  logic                   lz_ready;
  logic                   lz_neg;
  bcd_t                   lz_bcd;
  logic [DIGIT_IDX_W-1:0] lz_msd;
  logic [DIGIT_IDX_W-1:0] msd_next;

  // serializer
  logic                   busy;
  logic                   sign_pending;
  logic [DIGIT_IDX_W-1:0] pos;
  bcd_t                   digits;
  logic                   load_ready;

  assign in_ready  = !mag_valid || mag_ready;
  assign mag_ready = dr[0];
  assign dv[0]     = mag_valid;
  assign dw[0]     = mag_work;

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid <= 1'b0;
    end else if (in_ready) begin
      mag_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mag_work.neg <= value[VALUE_W-1];
      mag_work.bcd <= '0;
      mag_work.bin <= value[VALUE_W-1] ? (~value + 1'b1) : value;
    end
  end

  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
    sidc_dabble_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (dv[g]),
      .in_ready  (dr[g]),
      .in_work   (dw[g]),
      .out_valid (dv[g+1]),
      .out_ready (dr[g+1]),
      .out_work  (dw[g+1])
    );
  end

  assign dr[DABBLE_STAGES] = lz_ready;
  assign lz_ready          = !lz_valid || load_ready;

  always_comb begin
    msd_next = '0;
    for (int d = 0; d < int'(NUM_DIGITS); d++) begin
      if (dw[DABBLE_STAGES].bcd[d] != 4'd0) begin
        msd_next = DIGIT_IDX_W'(d);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lz_valid <= 1'b0;
    end else if (lz_ready) begin
      lz_valid <= dv[DABBLE_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (lz_ready && dv[DABBLE_STAGES]) begin
      lz_neg <= dw[DABBLE_STAGES].neg;
      lz_bcd <= dw[DABBLE_STAGES].bcd;
      lz_msd <= msd_next;
    end
  end

  // serializer output
  assign out_valid  = busy;
  assign last       = !sign_pending && (pos == '0);
  assign character  = sign_pending ? CHAR_MINUS : (CHAR_ZERO + {4'd0, digits[pos]});
  assign load_ready = !busy || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load_ready) begin
      busy <= lz_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && lz_valid) begin
      sign_pending <= lz_neg;
      pos          <= lz_msd;
      digits       <= lz_bcd;
    end else if (busy && out_ready) begin
      if (sign_pending) begin
        sign_pending <= 1'b0;
      end else if (pos != '0) begin
        pos <= pos - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/sidc_checker.sv -----
// port level checks for the converter and their binding to the top level
module sidc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [sidc_pkg::CHAR_W-1:0]    character,
  input logic                           last
);
  import sidc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
    else $error("output item changed while stalled");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CHAR_MINUS) ||
                  ((character >= CHAR_ZERO) && (character <= CHAR_ZERO + 8'd9)))
    else $error("output character is not a sign or digit");

  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (character == CHAR_MINUS) |-> !last)
    else $error("sign marked as final character");

  a_digit_after_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && (character == CHAR_MINUS) |=>
      out_valid && (character != CHAR_MINUS))
    else $error("sign not followed by a digit");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii_top sidc_checker u_sidc_checker (.*);
